// ===== hw/rtl/ttd_pkg.sv =====
// ----------------------------------------------------------------------------
// Turnover toggle detector package
// Shared widths, register indexes, constants and arithmetic helpers.
// ----------------------------------------------------------------------------
package ttd_pkg;

   // Field widths.
   localparam int SampleW = 16;
   localparam int FiltW   = 10;
   localparam int TickW   = 16;
   localparam int CsrIdxW = 4;
   localparam int CsrDatW = 16;

   // Saturation limits of the filter input.
   localparam logic signed [SampleW-1:0] SAMPLE_MAX = 16'sd511;
   localparam logic signed [SampleW-1:0] SAMPLE_MIN = -16'sd512;

   // Divide by ten as multiply by 205 / 2048, exact for magnitudes below 1024.
   localparam logic [7:0] DIV10_MUL   = 8'd205;
   localparam int         DIV10_SHIFT = 11;

   // Register reset values.
   localparam logic [TickW-1:0]        SAMPLE_EVERY_RST   = 16'd10;
   localparam logic signed [FiltW-1:0] TURN_THRESHOLD_RST = 10'sd220;

   // Configuration register indexes.
   typedef enum logic [CsrIdxW-1:0] {
      CSR_SAMPLE_EVERY   = 4'd0,
      CSR_TURN_THRESHOLD = 4'd1
   } csr_index_type;

   // Saturate a raw sample to the filter range.
   function automatic logic signed [FiltW-1:0] sat_sample(input logic signed [SampleW-1:0] s);
      logic signed [SampleW-1:0] c;
      begin
         if (s > SAMPLE_MAX) begin
            c = SAMPLE_MAX;
         end else if (s < SAMPLE_MIN) begin
            c = SAMPLE_MIN;
         end else begin
            c = s;
         end
         sat_sample = c[FiltW-1:0];
      end
   endfunction

   // Signed division by ten, truncated toward zero, for -1023..1023.
   function automatic logic signed [FiltW-1:0] div10(input logic signed [FiltW:0] d);
      logic [FiltW:0]   mag;
      logic [17:0]      prod;
      logic [6:0]       q;
      logic [FiltW-1:0] qx;
      begin
         mag  = d[FiltW] ? (~d + 11'd1) : d;
         prod = {8'd0, mag[FiltW-1:0]} * {10'd0, DIV10_MUL};
         q    = prod[17:DIV10_SHIFT];
         qx   = {3'd0, q};
         div10 = d[FiltW] ? $signed(~qx + 10'd1) : $signed(qx);
      end
   endfunction

endpackage

// ===== hw/rtl/turnover_toggle_detector.sv =====
// ----------------------------------------------------------------------------
// Turnover toggle detector
// Decimates a tick stream, low-pass filters the saturated axis sample and
// flips a lights flag on each rising edge of the filtered-above-threshold level.
// ----------------------------------------------------------------------------
// An accepted tick is held in the input register, then moves into the response register.
// Throughput: one tick per cycle while rsp_stall is low; the filter update sits
// between the input and response registers, so back-to-back ticks see fresh state.
// Reset: synchronous, active high; clears tick count, filter, level and
// lights flag, and loads sample_every = 10, turn_threshold = 220.
module turnover_toggle_detector
   import ttd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Tick input channel.
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [SampleW-1:0] req_accel_y,
   // Response channel.
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_sampled,
   output logic                      rsp_turned_over,
   output logic                      rsp_toggled,
   output logic                      rsp_lights_on,
   // Configuration write channel.
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CsrIdxW-1:0]        csr_index,
   input  logic [CsrDatW-1:0]        csr_wdata
);

   // Configuration registers.
   logic [TickW-1:0]        sample_every_ff;
   logic signed [FiltW-1:0] turn_threshold_ff;

   // Pipeline registers.
   logic                      in_valid_ff;
   logic signed [SampleW-1:0] accel_y_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_sampled_ff, rsp_turned_ff, rsp_toggled_ff, rsp_lights_ff;

   // Detector state.
   logic [TickW-1:0]        tick_count_ff, tick_count_in;
   logic signed [FiltW-1:0] filtered_ff, filtered_in;
   logic                    prev_turned_ff, prev_turned_in;
   logic                    lights_flag_ff, lights_flag_in;

   // Datapath signals.
   logic                    out_free;
   logic                    fire;
   logic                    in_take;
   logic [TickW-1:0]        tick_next;
   logic                    sample_c;
   logic signed [FiltW-1:0] sat_c;
   logic signed [FiltW:0]   diff_c;
   logic signed [FiltW-1:0] filt_new;
   logic                    level_c;
   logic                    toggle_c;

   // Handshake control: the response register frees when taken.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !fire;
   assign in_take   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_every_ff   <= SAMPLE_EVERY_RST;
         turn_threshold_ff <= TURN_THRESHOLD_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SAMPLE_EVERY:   sample_every_ff   <= csr_wdata[TickW-1:0];
            CSR_TURN_THRESHOLD: turn_threshold_ff <= $signed(csr_wdata[FiltW-1:0]);
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_take) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         accel_y_ff <= req_accel_y;
      end
   end

   // Decimation, saturation, filter step and edge detection.
   always_comb begin
      tick_next      = tick_count_ff + 16'd1;
      sample_c       = (tick_next >= sample_every_ff);
      sat_c          = sat_sample(accel_y_ff);
      diff_c         = {sat_c[FiltW-1], sat_c} - {filtered_ff[FiltW-1], filtered_ff};
      filt_new       = filtered_ff + div10(diff_c);
      level_c        = (filt_new > turn_threshold_ff);
      toggle_c       = sample_c && level_c && !prev_turned_ff;

      tick_count_in  = sample_c ? '0 : tick_next;
      filtered_in    = sample_c ? filt_new : filtered_ff;
      prev_turned_in = sample_c ? level_c : prev_turned_ff;
      lights_flag_in = lights_flag_ff ^ toggle_c;
   end

   // State update, one tick per fire.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff  <= '0;
         filtered_ff    <= '0;
         prev_turned_ff <= 1'b0;
         lights_flag_ff <= 1'b0;
      end else if (fire) begin
         tick_count_ff  <= tick_count_in;
         filtered_ff    <= filtered_in;
         prev_turned_ff <= prev_turned_in;
         lights_flag_ff <= lights_flag_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_sampled_ff <= sample_c;
         rsp_turned_ff  <= prev_turned_in;
         rsp_toggled_ff <= toggle_c;
         rsp_lights_ff  <= lights_flag_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sampled     = rsp_sampled_ff;
   assign rsp_turned_over = rsp_turned_ff;
   assign rsp_toggled     = rsp_toggled_ff;
   assign rsp_lights_on   = rsp_lights_ff;

   // A toggle can only be reported on a sampled tick.
   a_toggle_sampled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_toggled |-> rsp_sampled)
      else $error("toggle reported on an unsampled tick");

   // The lights flag changes only through a processed toggle.
   a_lights_change: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && !$stable(lights_flag_ff) |-> $past(fire && toggle_c))
      else $error("lights flag changed without a toggle");

   // A sampled tick restarts the tick count.
   a_tick_restart: assert property (@(posedge clock) disable iff (reset)
      fire && sample_c |=> tick_count_ff == '0)
      else $error("tick count not cleared after a sampled tick");

   // A held input item stays put until it is processed.
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(accel_y_ff))
      else $error("pending tick lost or changed");

endmodule

// ===== dv/ttd_checker.sv =====
// ----------------------------------------------------------------------------
// Turnover toggle detector checker
// Watches the tick, response and register channels of the detector. It keeps
// its own model of the tick counter, filter, turnover level and lights flag,
// predicts one status per accepted tick and compares every accepted response
// with the oldest prediction.
// ----------------------------------------------------------------------------
module ttd_checker
   import ttd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic signed [SampleW-1:0] req_accel_y,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic                      rsp_sampled,
   input  logic                      rsp_turned_over,
   input  logic                      rsp_toggled,
   input  logic                      rsp_lights_on,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CsrIdxW-1:0]        csr_index,
   input  logic [CsrDatW-1:0]        csr_wdata,
   output int                        fail_count,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FilterDiv  = 10;
   localparam int ReportLimit = 10;

   typedef struct packed {
      logic sampled;
      logic turned_over;
      logic toggled;
      logic lights_on;
   } tick_status_type;

   // Predicted statuses, oldest first.
   tick_status_type expected_status_q[$];

   // Register copies.
   logic [TickW-1:0]        period;
   logic signed [FiltW-1:0] threshold;

   // Detector state as the checker sees it.
   logic [TickW-1:0]        tick_count;
   logic signed [FiltW-1:0] filt_value;
   logic                    level;
   logic                    lights;

   // Advance the model by one tick and return the status it should report.
   task automatic predict_tick(input logic signed [SampleW-1:0] accel,
                               output tick_status_type st);
      int   clamped;
      int   step;
      logic now_above;
      st = '0;
      tick_count = tick_count + 1'b1;
      if (tick_count >= period) begin
         tick_count = '0;
         clamped = accel;
         if (clamped > int'(SAMPLE_MAX)) clamped = SAMPLE_MAX;
         if (clamped < int'(SAMPLE_MIN)) clamped = SAMPLE_MIN;
         // Integer division in SystemVerilog truncates toward zero.
         step = (clamped - int'(filt_value)) / FilterDiv;
         filt_value = FiltW'(int'(filt_value) + step);
         now_above = int'(filt_value) > int'(threshold);
         if (now_above && !level) begin
            lights = ~lights;
            st.toggled = 1'b1;
         end
         level = now_above;
         st.sampled = 1'b1;
      end
      st.turned_over = level;
      st.lights_on = lights;
   endtask

   // Sample every channel on the rising edge; responses are checked before
   // the tick of the same edge is predicted.
   always @(posedge clock) begin
      tick_status_type got;
      tick_status_type want;
      if (reset) begin
         period = SAMPLE_EVERY_RST;
         threshold = TURN_THRESHOLD_RST;
         tick_count = '0;
         filt_value = '0;
         level = 1'b0;
         lights = 1'b0;
         expected_status_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SAMPLE_EVERY) begin
               period = csr_wdata[TickW-1:0];
            end else if (csr_index == CSR_TURN_THRESHOLD) begin
               threshold = csr_wdata[FiltW-1:0];
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_sampled, rsp_turned_over, rsp_toggled, rsp_lights_on};
            if (expected_status_q.size() == 0) begin
               fail_count++;
               if (fail_count <= ReportLimit) begin
                  $display("%0t: response transaction with nothing predicted: sampled=%b",
                           $realtime, got.sampled,
                           " turned_over=%b toggled=%b lights_on=%b",
                           got.turned_over, got.toggled, got.lights_on);
               end
            end else begin
               want = expected_status_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= ReportLimit) begin
                     $display("%0t: status mismatch: sampled exp %b got %b,", $realtime,
                              want.sampled, got.sampled,
                              " turned_over exp %b got %b, toggled exp %b got %b,",
                              want.turned_over, got.turned_over, want.toggled, got.toggled,
                              " lights_on exp %b got %b", want.lights_on, got.lights_on);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_tick(req_accel_y, want);
            expected_status_q.push_back(want);
         end
      end
      pending = expected_status_q.size();
   end

endmodule

// ===== dv/tb_turnover_toggle_detector.sv =====
// ----------------------------------------------------------------------------
// Turnover toggle detector testbench
// Drives tick transactions in random bursts against a randomly stalling
// receiver, walks the sample period and threshold registers through their
// extremes and random settings, and lets the checker score every response.
// ----------------------------------------------------------------------------
module tb_turnover_toggle_detector
   import ttd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomTicks = 500;
   localparam int HoldCycles  = 60;
   localparam int DrainCycles = 4;

   // An index with no register behind it; writes to it must change nothing.
   localparam logic [CsrIdxW-1:0] CSR_UNMAPPED = '1;

   typedef enum {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_EVERY_THIRD
   } stall_mode_type;

   // Samples around the threshold of 40 that make the level rise and fall
   // again, with every saturation boundary on the way.
   localparam logic signed [SampleW-1:0] EdgeRun [11] = '{
      16'sd32767, 16'sd512, 16'sd511, -16'sd32768, -16'sd513, -16'sd512,
      -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd0
   };

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [SampleW-1:0] req_accel_y;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_sampled;
   logic                      rsp_turned_over;
   logic                      rsp_toggled;
   logic                      rsp_lights_on;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CsrIdxW-1:0]        csr_index;
   logic [CsrDatW-1:0]        csr_wdata;
   int                        fail_count;
   int                        pending;

   logic                      hold_off_now = 1'b0;
   int                        burst_left;
   int                        seg_left;
   logic signed [SampleW-1:0] seg_target;

   turnover_toggle_detector uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_accel_y     (req_accel_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sampled     (rsp_sampled),
      .rsp_turned_over (rsp_turned_over),
      .rsp_toggled     (rsp_toggled),
      .rsp_lights_on   (rsp_lights_on),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   ttd_checker status_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_accel_y     (req_accel_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sampled     (rsp_sampled),
      .rsp_turned_over (rsp_turned_over),
      .rsp_toggled     (rsp_toggled),
      .rsp_lights_on   (rsp_lights_on),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #3ms;
      $display("Test completed with failures");
      $finish;
   end

   // The receiver stalls on a pattern in one of four modes, drawn anew at random
   // when a mode runs out, and holds off for a long stretch when asked to.
   initial begin
      stall_mode_type mode;
      int             mode_left;
      int             beat;
      mode = STALL_NONE;
      mode_left = 0;
      beat = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_now) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(negedge clock);
            hold_off_now = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            beat++;
            case (mode)
               STALL_NONE: begin
                  rsp_stall <= 1'b0;
               end
               STALL_LIGHT: begin
                  rsp_stall <= ($urandom_range(0, 3) == 0);
               end
               STALL_HEAVY: begin
                  rsp_stall <= ($urandom_range(0, 3) != 0);
               end
               default: begin
                  rsp_stall <= (beat % 3 == 0);
               end
            endcase
         end
      end
   end

   // Offer one tick transaction and wait until it is taken. Starts and ends
   // on a falling edge; a finished burst is followed by a random gap.
   task automatic send_tick(input logic signed [SampleW-1:0] accel);
      req_valid <= 1'b1;
      req_accel_y <= accel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
   endtask

   // Stop offering ticks and wait until every predicted status has arrived.
   task automatic wait_drained();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      while (pending != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // One register write transaction.
   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDatW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly short periods so that many ticks are filtered; now and then a
   // zero period or a huge one that a later phase lowers again.
   task automatic write_random_config();
      int                  pick;
      logic [CsrDatW-1:0]  data;
      pick = $urandom_range(0, 19);
      if ($urandom_range(0, 9) < 7) begin
         if (pick < 3) begin
            data = '0;
         end else if (pick < 15) begin
            data = CsrDatW'($urandom_range(1, 3));
         end else if (pick < 19) begin
            data = CsrDatW'($urandom_range(4, 12));
         end else begin
            data = CsrDatW'($urandom());
         end
         write_reg(CSR_SAMPLE_EVERY, data);
      end
      if ($urandom_range(0, 9) < 7) begin
         // Upper bits are random; only the low bits hold the threshold.
         data = CsrDatW'($urandom());
         data[FiltW-1:0] = FiltW'(int'($urandom_range(0, 600)) - 300);
         write_reg(CSR_TURN_THRESHOLD, data);
      end
   endtask

   // Samples come in runs around a target so the filter settles on either
   // side of the threshold; a share of them is full-range noise.
   function automatic logic signed [SampleW-1:0] next_accel();
      int jitter;
      if (seg_left <= 0) begin
         seg_left = $urandom_range(5, 30);
         if ($urandom_range(0, 3) == 0) begin
            seg_target = ($urandom_range(0, 1) == 1) ? 16'sd2000 : -16'sd2000;
         end else begin
            seg_target = SampleW'(int'($urandom_range(0, 1200)) - 600);
         end
      end
      seg_left--;
      if ($urandom_range(0, 99) < 15) begin
         return SampleW'($urandom());
      end
      jitter = int'($urandom_range(0, 128)) - 64;
      return SampleW'(int'(seg_target) + jitter);
   endfunction

   initial begin
      int sent;
      int phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_accel_y = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      burst_left = 8;
      seg_left = 0;
      seg_target = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: nine ignored ticks, then the tenth is filtered.
      repeat (9) send_tick(SampleW'($urandom()));
      send_tick(16'sd32767);
      wait_drained();

      // Zero period samples every tick; the run crosses the threshold twice.
      write_reg(CSR_SAMPLE_EVERY, '0);
      write_reg(CSR_TURN_THRESHOLD, 16'd40);
      foreach (EdgeRun[i]) send_tick(EdgeRun[i]);
      wait_drained();

      // Largest period and threshold: nothing is filtered.
      write_reg(CSR_SAMPLE_EVERY, 16'hFFFF);
      write_reg(CSR_TURN_THRESHOLD, 16'd511);
      repeat (3) send_tick(SampleW'($urandom()));
      wait_drained();

      // Period lowered below the count, lowest threshold, and a write to an
      // unmapped index that must leave both registers alone.
      write_reg(CSR_SAMPLE_EVERY, 16'd1);
      write_reg(CSR_TURN_THRESHOLD, 16'hFE00);
      write_reg(CSR_UNMAPPED, 16'hFFFF);
      send_tick(16'sd300);
      send_tick(-16'sd300);

      // Random phases, each starting from an idle block.
      sent = 0;
      phase = 0;
      while (sent < RandomTicks) begin
         wait_drained();
         write_random_config();
         if (phase == 3) hold_off_now = 1'b1;
         repeat ($urandom_range(20, 60)) begin
            send_tick(next_accel());
            sent++;
         end
         phase++;
      end

      wait_drained();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
